// File: design/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion unit
`default_nettype none
package rmq_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int DATA_W     = 16;
   localparam int CAND_W     = DATA_W + 2;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int SUM_W      = DATA_W + 1;
   localparam int RAD_W      = 2 * DATA_W;
   localparam int ROOT_W     = DATA_W;
   localparam int SREM_W     = ROOT_W + 4;
   localparam int DEN_W      = DATA_W + 1;
   localparam int QUO_W      = DATA_W + 1;
   localparam int DVD_W      = DATA_W + FRAC_BITS + 1;
   localparam int LANES      = 3;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int NUM_STAGES = SQRT_STEPS + DIV_STEPS + 2;
   localparam int PREP_IDX   = SQRT_STEPS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] PICK_W = 2'd0;
   localparam logic [1:0] PICK_X = 2'd1;
   localparam logic [1:0] PICK_Y = 2'd2;
   localparam logic [1:0] PICK_Z = 2'd3;

   typedef struct packed {
      logic [1:0]                     pick;
      logic [SUM_W-1:0]               s;
      logic signed [LANES-1:0][DIFF_W-1:0] d;
   } front_item_type;

   typedef struct packed {
      logic [1:0]                     pick;
      logic signed [LANES-1:0][DIFF_W-1:0] d;
      logic [RAD_W-1:0]               sv;
      logic [SREM_W-1:0]              srem;
      logic [ROOT_W-1:0]              root;
      logic [DEN_W-1:0]               den;
      logic [LANES-1:0]               neg;
      logic [LANES-1:0][DEN_W-1:0]    dd;
      logic [LANES-1:0][DEN_W-1:0]    drem;
      logic [LANES-1:0][QUO_W-1:0]    quo;
   } back_stage_type;

endpackage
`default_nettype wire

// File: design/rmq_front.sv
// front end: candidate traces, largest pick and off-diagonal terms
`default_nettype none
module rmq_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [15:0]           req_m11,
   input  wire logic signed [15:0]           req_m12,
   input  wire logic signed [15:0]           req_m13,
   input  wire logic signed [15:0]           req_m21,
   input  wire logic signed [15:0]           req_m22,
   input  wire logic signed [15:0]           req_m23,
   input  wire logic signed [15:0]           req_m31,
   input  wire logic signed [15:0]           req_m32,
   input  wire logic signed [15:0]           req_m33,
   output logic                              item_valid,
   input  wire logic                         item_full,
   output rmq_pkg::front_item_type           item
);

   logic                                     vld_ff, vld_in;
   rmq_pkg::front_item_type                  item_ff, item_in;
   logic signed [rmq_pkg::CAND_W-1:0]        c0, c1, c2, c3, best;
   logic signed [rmq_pkg::CAND_W-1:0]        a11, a22, a33;
   logic signed [rmq_pkg::DIFF_W-1:0]        dw_x, dw_y, dw_z, s_xy, s_xz, s_yz;
   logic [1:0]                               pick;
   logic                                     take;

   assign req_stall  = vld_ff && item_full;
   assign take       = req_valid && !req_stall;
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_comb begin
      a11 = rmq_pkg::CAND_W'(req_m11);
      a22 = rmq_pkg::CAND_W'(req_m22);
      a33 = rmq_pkg::CAND_W'(req_m33);
      c0 = a11 + a22 + a33;
      c1 = a11 - a22 - a33;
      c2 = a22 - a11 - a33;
      c3 = a33 - a11 - a22;
      best = c0;
      pick = rmq_pkg::PICK_W;
      if (c1 > best) begin
         best = c1;
         pick = rmq_pkg::PICK_X;
      end
      if (c2 > best) begin
         best = c2;
         pick = rmq_pkg::PICK_Y;
      end
      if (c3 > best) begin
         best = c3;
         pick = rmq_pkg::PICK_Z;
      end
      dw_x = rmq_pkg::DIFF_W'(req_m23) - rmq_pkg::DIFF_W'(req_m32);
      dw_y = rmq_pkg::DIFF_W'(req_m31) - rmq_pkg::DIFF_W'(req_m13);
      dw_z = rmq_pkg::DIFF_W'(req_m12) - rmq_pkg::DIFF_W'(req_m21);
      s_xy = rmq_pkg::DIFF_W'(req_m12) + rmq_pkg::DIFF_W'(req_m21);
      s_xz = rmq_pkg::DIFF_W'(req_m31) + rmq_pkg::DIFF_W'(req_m13);
      s_yz = rmq_pkg::DIFF_W'(req_m23) + rmq_pkg::DIFF_W'(req_m32);
      item_in.pick = pick;
      item_in.s = rmq_pkg::SUM_W'(best) + rmq_pkg::SUM_W'(1 << rmq_pkg::FRAC_BITS);
      unique case (pick)
         rmq_pkg::PICK_W: begin
            item_in.d[0] = dw_x; item_in.d[1] = dw_y; item_in.d[2] = dw_z;
         end
         rmq_pkg::PICK_X: begin
            item_in.d[0] = dw_x; item_in.d[1] = s_xy; item_in.d[2] = s_xz;
         end
         rmq_pkg::PICK_Y: begin
            item_in.d[0] = dw_y; item_in.d[1] = s_xy; item_in.d[2] = s_yz;
         end
         default: begin
            item_in.d[0] = dw_z; item_in.d[1] = s_xz; item_in.d[2] = s_yz;
         end
      endcase
      vld_in = take || (vld_ff && item_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// File: design/rmq_queue.sv
// short request queue between the front end and the arithmetic pipeline
`default_nettype none
module rmq_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         full,
   input  wire rmq_pkg::front_item_type push_item,
   output logic                         pop_valid,
   input  wire logic                    pop,
   output rmq_pkg::front_item_type      pop_item
);

   rmq_pkg::front_item_type             mem_ff [rmq_pkg::QUEUE_DEPTH];
   logic [rmq_pkg::QPTR_W-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [rmq_pkg::QPTR_W:0]            cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full      = cnt_ff == (rmq_pkg::QPTR_W+1)'(rmq_pkg::QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_item  = mem_ff[rd_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (rmq_pkg::QPTR_W+1)'(do_push) - (rmq_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (rmq_pkg::QPTR_W+1)'(rmq_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      rmq_pkg::QPTR_W'(wr_ff - rd_ff) == rmq_pkg::QPTR_W'(cnt_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// File: design/rmq_back.sv
// back end: pipelined square root, three pipelined dividers, output register
`default_nettype none
module rmq_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_pop,
   input  wire rmq_pkg::front_item_type in_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [15:0]           rsp_quat_w,
   output logic signed [15:0]           rsp_quat_x,
   output logic signed [15:0]           rsp_quat_y,
   output logic signed [15:0]           rsp_quat_z,
   output logic [1:0]                   rsp_largest_pick
);

   localparam int N = rmq_pkg::NUM_STAGES;

   rmq_pkg::back_stage_type             st_ff [N];
   rmq_pkg::back_stage_type             st_in [N];
   logic [N-1:0]                        vld_ff, vld_in;
   logic [N:0]                          go;
   logic                                out_vld_ff;
   logic [3:0][15:0]                    out_ff, out_in;
   logic [1:0]                          opick_ff;

   function automatic rmq_pkg::back_stage_type sqrt_step(rmq_pkg::back_stage_type x);
      rmq_pkg::back_stage_type  y;
      logic [rmq_pkg::SREM_W-1:0] r, t;
      y = x;
      r = {x.srem[rmq_pkg::SREM_W-3:0], x.sv[rmq_pkg::RAD_W-1 -: 2]};
      t = rmq_pkg::SREM_W'({x.root, 2'b01});
      y.sv = {x.sv[rmq_pkg::RAD_W-3:0], 2'b00};
      if (r >= t) begin
         y.srem = r - t;
         y.root = {x.root[rmq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         y.srem = r;
         y.root = {x.root[rmq_pkg::ROOT_W-2:0], 1'b0};
      end
      return y;
   endfunction

   function automatic rmq_pkg::back_stage_type prep(rmq_pkg::back_stage_type x);
      rmq_pkg::back_stage_type  y;
      logic [rmq_pkg::DEN_W-1:0] mag;
      logic [rmq_pkg::DVD_W-1:0] dvd;
      y = x;
      y.den = rmq_pkg::DEN_W'({x.root[rmq_pkg::ROOT_W-1:1], 2'b00});
      for (int k = 0; k < rmq_pkg::LANES; k++) begin
         y.neg[k] = x.d[k][rmq_pkg::DIFF_W-1];
         mag = y.neg[k] ? rmq_pkg::DEN_W'(-x.d[k]) : rmq_pkg::DEN_W'(x.d[k]);
         dvd = (rmq_pkg::DVD_W'(mag) << rmq_pkg::FRAC_BITS)
             + rmq_pkg::DVD_W'({x.root[rmq_pkg::ROOT_W-1:1], 1'b0});
         y.drem[k] = rmq_pkg::DEN_W'(dvd[rmq_pkg::DVD_W-1:rmq_pkg::QUO_W]);
         y.dd[k]   = dvd[rmq_pkg::QUO_W-1:0];
         y.quo[k]  = '0;
      end
      return y;
   endfunction

   function automatic rmq_pkg::back_stage_type div_step(rmq_pkg::back_stage_type x);
      rmq_pkg::back_stage_type  y;
      logic [rmq_pkg::DEN_W:0]  r;
      y = x;
      for (int k = 0; k < rmq_pkg::LANES; k++) begin
         r = {x.drem[k], x.dd[k][rmq_pkg::DEN_W-1]};
         y.dd[k] = {x.dd[k][rmq_pkg::DEN_W-2:0], 1'b0};
         if (r >= (rmq_pkg::DEN_W+1)'(x.den)) begin
            y.drem[k] = rmq_pkg::DEN_W'(r - (rmq_pkg::DEN_W+1)'(x.den));
            y.quo[k]  = {x.quo[k][rmq_pkg::QUO_W-2:0], 1'b1};
         end else begin
            y.drem[k] = rmq_pkg::DEN_W'(r);
            y.quo[k]  = {x.quo[k][rmq_pkg::QUO_W-2:0], 1'b0};
         end
      end
      return y;
   endfunction

   function automatic logic [15:0] sat_lane(logic [rmq_pkg::QUO_W-1:0] q, logic neg);
      logic [rmq_pkg::QUO_W-1:0] nq;
      nq = rmq_pkg::QUO_W'(0) - q;
      if (neg) begin
         return (q > rmq_pkg::QUO_W'(32768)) ? 16'h8000 : nq[15:0];
      end
      return (q > rmq_pkg::QUO_W'(32767)) ? 16'h7fff : q[15:0];
   endfunction

   always_comb begin
      go[N] = !out_vld_ff || !rsp_stall;
      for (int i = N - 1; i >= 0; i--) begin
         go[i] = !vld_ff[i] || go[i+1];
      end
      in_pop = go[0];
      vld_in[0] = in_valid;
      st_in[0] = '0;
      st_in[0].pick = in_item.pick;
      st_in[0].d    = in_item.d;
      st_in[0].sv   = rmq_pkg::RAD_W'(in_item.s) << rmq_pkg::FRAC_BITS;
      for (int i = 1; i < N; i++) begin
         vld_in[i] = vld_ff[i-1];
         if (i <= rmq_pkg::PREP_IDX) begin
            st_in[i] = sqrt_step(st_ff[i-1]);
         end else if (i == rmq_pkg::PREP_IDX + 1) begin
            st_in[i] = prep(st_ff[i-1]);
         end else begin
            st_in[i] = div_step(st_ff[i-1]);
         end
      end
   end

   always_comb begin
      logic [15:0] big;
      logic [2:0][15:0] ln;
      big = {1'b0, st_ff[N-1].root[rmq_pkg::ROOT_W-1:1]};
      for (int k = 0; k < rmq_pkg::LANES; k++) begin
         ln[k] = sat_lane(st_ff[N-1].quo[k], st_ff[N-1].neg[k]);
      end
      unique case (st_ff[N-1].pick)
         rmq_pkg::PICK_W: out_in = {ln[2], ln[1], ln[0], big};
         rmq_pkg::PICK_X: out_in = {ln[2], ln[1], big, ln[0]};
         rmq_pkg::PICK_Y: out_in = {ln[2], big, ln[1], ln[0]};
         default:         out_in = {big, ln[2], ln[1], ln[0]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (go[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
         if (go[N]) begin
            out_vld_ff <= vld_ff[N-1];
         end
      end
      for (int i = 0; i < N; i++) begin
         if (go[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
      if (go[N]) begin
         out_ff   <= out_in;
         opick_ff <= st_ff[N-1].pick;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_quat_w       = out_ff[0];
   assign rsp_quat_x       = out_ff[1];
   assign rsp_quat_y       = out_ff[2];
   assign rsp_quat_z       = out_ff[3];
   assign rsp_largest_pick = opick_ff;

`ifndef NO_ASSERTIONS
   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_ff[rsp_largest_pick] >= 16'd8192
                     && out_ff[rsp_largest_pick] <= 16'd23170))
      else $error("picked component outside its range");
   a_prep_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[rmq_pkg::PREP_IDX+1] |-> st_ff[rmq_pkg::PREP_IDX+1].den != '0)
      else $error("zero divisor in pipeline");
`endif

endmodule
`default_nettype wire

// File: design/rotation_matrix_to_quaternion_unit.sv
// top level of the rotation matrix to quaternion unit
// usage:
//   req_* carries one 3x3 rotation matrix in signed q2.14 per request; a request
//   is taken at a clock edge with req_valid high and req_stall low.
//   rsp_* returns the quaternion (w, x, y, z) in signed q2.14, saturated, and
//   which component was largest; taken when rsp_valid is high and rsp_stall low.
// path: from the accepting edge to rsp_valid a request passes the front
//   register, the queue, 35 pipeline stages (input register, 16 square
//   root steps, one divisor setup, 17 divide steps) and the output register,
//   which also picks and saturates.
// throughput: one request per cycle while rsp_stall stays low; every pipeline
//   stage moves on its own, so bubbles close up while the response side stalls.
// reset: synchronous, active high; empties the front register, queue and
//   pipeline; requests in flight at reset are dropped.
// stall: with rsp_stall high the pipeline fills, then the 4-entry queue, then
//   the front register, after which req_stall rises.
`default_nettype none
module rotation_matrix_to_quaternion_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_m11,
   input  wire logic signed [15:0] req_m12,
   input  wire logic signed [15:0] req_m13,
   input  wire logic signed [15:0] req_m21,
   input  wire logic signed [15:0] req_m22,
   input  wire logic signed [15:0] req_m23,
   input  wire logic signed [15:0] req_m31,
   input  wire logic signed [15:0] req_m32,
   input  wire logic signed [15:0] req_m33,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_quat_w,
   output logic signed [15:0]      rsp_quat_x,
   output logic signed [15:0]      rsp_quat_y,
   output logic signed [15:0]      rsp_quat_z,
   output logic [1:0]              rsp_largest_pick
);

   logic                     f_valid, q_full, q_valid, q_pop;
   rmq_pkg::front_item_type  f_item, q_item;

   rmq_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m11(req_m11), .req_m12(req_m12), .req_m13(req_m13),
      .req_m21(req_m21), .req_m22(req_m22), .req_m23(req_m23),
      .req_m31(req_m31), .req_m32(req_m32), .req_m33(req_m33),
      .item_valid(f_valid), .item_full(q_full), .item(f_item)
   );

   rmq_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .full(q_full), .push_item(f_item),
      .pop_valid(q_valid), .pop(q_pop), .pop_item(q_item)
   );

   rmq_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_pop(q_pop), .in_item(q_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_largest_pick(rsp_largest_pick)
   );

`ifndef NO_ASSERTIONS
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (f_valid && q_full) |=> f_valid)
      else $error("front request dropped while queue full");
`endif

endmodule
`default_nettype wire
